[src/wmd_pkg.sv]
// Package: constants, types and codes for the windowed median detrend block.
package wmd_pkg;
	localparam int unsigned DefMaxRows = 512;
	localparam int unsigned DefMaxCols = 512;
	localparam int unsigned DefMaxHalf = 15;
	localparam int unsigned CfgW = 10;
	localparam int unsigned ValW = 16;
	localparam int unsigned PertW = 18;
	localparam int unsigned IdxW = 2;

	typedef enum logic [IdxW-1:0] {
		REG_ROWS = 2'd0,
		REG_COLS = 2'd1,
		REG_HROWS = 2'd2,
		REG_HCOLS = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CENTER,
		ST_CHECK,
		ST_GATHER,
		ST_GDRAIN,
		ST_SEL_INIT,
		ST_COUNT,
		ST_CDRAIN,
		ST_DECIDE,
		ST_NEXTK,
		ST_FINISH,
		ST_OUT
	} state_t;
endpackage

[src/wmd_if.sv]
// Interfaces: input word channel and result word channel.
interface wmd_in_if;
	logic valid;
	logic ready;
	logic op;
	logic [8:0] row;
	logic [8:0] col;
	logic [15:0] sample_value;
	logic sample_ok;
	modport source (output valid, op, row, col, sample_value, sample_ok, input ready);
	modport sink (input valid, op, row, col, sample_value, sample_ok, output ready);
endinterface

interface wmd_out_if;
	logic valid;
	logic ready;
	logic signed [17:0] perturbation;
	logic result_ok;
	modport source (output valid, perturbation, result_ok, input ready);
	modport sink (input valid, perturbation, result_ok, output ready);
endinterface

[src/windowed_median_detrend.sv]
// Top level: grid memory, window buffer and radix median selection.
//  channel | dir | handshake    | payload
//  in_ch   | in  | valid/ready  | op, row, col, sample_value, sample_ok
//  out_ch  | out | valid/ready  | perturbation, result_ok
//  cfg     | in  | cfg_we       | cfg_index, cfg_data
// A write word is taken while idle; writes can follow back to back.
// A query gathers the N window cells, keeps the M valid ones, then selects bit by
// bit, with one selection pass for odd M and two for even M.
// The window buffer has a single read port: one entry per cycle per bit pass.
// Reset clears control and sets config to 512x512, half-window 10; memories hold garbage until written.
// A finished result waits in the output register; while out.ready is low no input word is taken.
module windowed_median_detrend
	import wmd_pkg::*;
#(
	parameter int unsigned MAX_ROWS = DefMaxRows,
	parameter int unsigned MAX_COLS = DefMaxCols,
	parameter int unsigned MAX_HALF = DefMaxHalf
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [IdxW-1:0] cfg_index,
	input logic [CfgW-1:0] cfg_data,
	wmd_in_if.sink in_ch,
	wmd_out_if.source out_ch
);
	localparam int unsigned GD = MAX_ROWS * MAX_COLS;
	localparam int unsigned GAW = (GD > 1) ? $clog2(GD) : 1;
	localparam int unsigned WS = 2 * MAX_HALF + 1;
	localparam int unsigned WD = WS * WS;
	localparam int unsigned WAW = (WD > 1) ? $clog2(WD) : 1;
	localparam int unsigned NW = $clog2(WD + 1);
	localparam int unsigned HW = 5;

	logic [ValW:0] grid_mem [GD];
	logic [ValW-1:0] win_mem [WD];

	state_t state_q, state_d;
	logic [CfgW-1:0] rows_q, cols_q;
	logic [3:0] hr_cfg_q, hc_cfg_q;

	logic [8:0] row_q, col_q;
	logic [ValW-1:0] center_q;
	logic [CfgW:0] r_q, c_q, r1_q, c0_q, c1_q;
	logic rd_pend_s1;
	logic [NW-1:0] n_q, idx_q, k_q, cnt_q;
	logic [3:0] bit_q;
	logic [ValW-1:0] prefix_q;
	logic pass_q;
	logic [ValW:0] sum_q;
	logic signed [PertW-1:0] pert_q;
	logic ok_q;

	logic [ValW:0] grid_rd_s1;
	logic [ValW-1:0] win_rd_s1;
	logic grid_we, win_we, win_rd_en;
	logic [GAW-1:0] grid_wa, grid_ra;
	logic [ValW:0] grid_wd;

	logic [CfgW:0] nr, nc, hr, hc;
	always_comb begin
		nr = {1'b0, rows_q};
		if (rows_q == '0) nr = (CfgW+1)'(1);
		else if ({1'b0, rows_q} > (CfgW+1)'(MAX_ROWS)) nr = (CfgW+1)'(MAX_ROWS);
		nc = {1'b0, cols_q};
		if (cols_q == '0) nc = (CfgW+1)'(1);
		else if ({1'b0, cols_q} > (CfgW+1)'(MAX_COLS)) nc = (CfgW+1)'(MAX_COLS);
		hr = (CfgW+1)'(hr_cfg_q);
		if ({1'b0, hr_cfg_q} > HW'(MAX_HALF)) hr = (CfgW+1)'(MAX_HALF);
		hc = (CfgW+1)'(hc_cfg_q);
		if ({1'b0, hc_cfg_q} > HW'(MAX_HALF)) hc = (CfgW+1)'(MAX_HALF);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= CfgW'(512);
			cols_q <= CfgW'(512);
			hr_cfg_q <= 4'd10;
			hc_cfg_q <= 4'd10;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_ROWS: rows_q <= cfg_data;
				REG_COLS: cols_q <= cfg_data;
				REG_HROWS: hr_cfg_q <= cfg_data[3:0];
				REG_HCOLS: hc_cfg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// grid memory
	logic in_fire;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE);
	always_comb begin
		grid_we = in_fire && (in_ch.op == OP_WRITE) && (32'(in_ch.row) < MAX_ROWS)
			&& (32'(in_ch.col) < MAX_COLS);
		grid_wa = GAW'(32'(in_ch.row) * MAX_COLS + 32'(in_ch.col));
		grid_wd = {in_ch.sample_ok, in_ch.sample_value};
		if (state_q == ST_CENTER) grid_ra = GAW'(32'(row_q) * MAX_COLS + 32'(col_q));
		else grid_ra = GAW'(32'(r_q) * MAX_COLS + 32'(c_q));
	end
	always_ff @(posedge clk) begin
		if (grid_we) grid_mem[grid_wa] <= grid_wd;
		grid_rd_s1 <= grid_mem[grid_ra];
	end

	// window buffer
	assign win_we = rd_pend_s1 && grid_rd_s1[ValW] && (n_q < NW'(WD));
	assign win_rd_en = (state_q == ST_COUNT);
	always_ff @(posedge clk) begin
		if (win_we) win_mem[n_q[WAW-1:0]] <= grid_rd_s1[ValW-1:0];
		if (win_rd_en) win_rd_s1 <= win_mem[idx_q[WAW-1:0]];
	end

	logic [ValW-1:0] hmask;
	logic hit;
	always_comb begin
		hmask = ValW'(17'h1FFFF << (bit_q + 5'd1));
		hit = ((win_rd_s1 & hmask) == prefix_q) && !win_rd_s1[bit_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	logic gather_last, count_last, win_empty;
	always_comb begin
		gather_last = (c_q == c1_q) && (r_q == r1_q);
		count_last = (idx_q == n_q - NW'(1));
		win_empty = (n_q == '0);
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_fire && in_ch.op == OP_QUERY) state_d = ST_CENTER;
			ST_CENTER: begin
				if ({2'b0, row_q} >= nr || {2'b0, col_q} >= nc) state_d = ST_OUT;
				else state_d = ST_CHECK;
			end
			ST_CHECK: state_d = grid_rd_s1[ValW] ? ST_GATHER : ST_OUT;
			ST_GATHER: if (gather_last) state_d = ST_GDRAIN;
			ST_GDRAIN: state_d = ST_SEL_INIT;
			ST_SEL_INIT: state_d = win_empty ? ST_OUT : ST_COUNT;
			ST_COUNT: if (count_last) state_d = ST_CDRAIN;
			ST_CDRAIN: state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (bit_q != 4'd0) state_d = ST_COUNT;
				else state_d = ST_NEXTK;
			end
			ST_NEXTK: state_d = (pass_q || n_q[0]) ? ST_FINISH : ST_COUNT;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT: if (out_ch.ready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_s1 <= 1'b0;
			ok_q <= 1'b0;
		end else begin
			rd_pend_s1 <= (state_q == ST_GATHER);
			if (state_q == ST_CENTER) ok_q <= 1'b0;
			if (state_q == ST_FINISH) ok_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (win_we) n_q <= n_q + NW'(1);
		if (state_q == ST_COUNT && idx_q != '0 && hit) cnt_q <= cnt_q + NW'(1);
		case (state_q)
			ST_IDLE: begin
				row_q <= in_ch.row;
				col_q <= in_ch.col;
			end
			ST_CENTER: begin
				pert_q <= '0;
				n_q <= '0;
				r_q <= ({2'b0, row_q} > hr) ? {2'b0, row_q} - hr : '0;
				r1_q <= ({2'b0, row_q} + hr < nr) ? {2'b0, row_q} + hr : nr - 1'b1;
				c0_q <= ({2'b0, col_q} > hc) ? {2'b0, col_q} - hc : '0;
				c_q <= ({2'b0, col_q} > hc) ? {2'b0, col_q} - hc : '0;
				c1_q <= ({2'b0, col_q} + hc < nc) ? {2'b0, col_q} + hc : nc - 1'b1;
			end
			ST_CHECK: center_q <= grid_rd_s1[ValW-1:0];
			ST_GATHER: begin
				if (c_q == c1_q) begin
					c_q <= c0_q;
					r_q <= r_q + 1'b1;
				end else c_q <= c_q + 1'b1;
			end
			ST_SEL_INIT: begin
				bit_q <= 4'd15;
				prefix_q <= '0;
				idx_q <= '0;
				cnt_q <= '0;
				pass_q <= 1'b0;
				sum_q <= '0;
				k_q <= n_q[0] ? (n_q >> 1) : (n_q >> 1) - NW'(1);
			end
			ST_COUNT: if (!count_last) idx_q <= idx_q + NW'(1);
			ST_CDRAIN: if (hit) cnt_q <= cnt_q + NW'(1);
			ST_DECIDE: begin
				if (k_q >= cnt_q) begin
					k_q <= k_q - cnt_q;
					prefix_q <= prefix_q | (ValW'(1) << bit_q);
				end
				bit_q <= bit_q - 4'd1;
				idx_q <= '0;
				cnt_q <= '0;
			end
			ST_NEXTK: if (!pass_q) begin
				sum_q <= n_q[0] ? {prefix_q, 1'b0} : (ValW+1)'(prefix_q);
				pass_q <= 1'b1;
				prefix_q <= '0;
				bit_q <= 4'd15;
				k_q <= n_q >> 1;
			end
			ST_FINISH: pert_q <= PertW'({1'b0, center_q, 1'b0})
				- PertW'(pass_q ? sum_q + (ValW+1)'(prefix_q) : sum_q);
			default: ;
		endcase
	end

	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.perturbation = ok_q ? pert_q : '0;
	assign out_ch.result_ok = ok_q;

	property p_ready_idle;
		@(posedge clk) disable iff (!arst_n) out_ch.valid |-> !in_ch.ready;
	endproperty
	a_ready_idle: assert property (p_ready_idle) else $error("input taken while result pending");

	property p_out_hold;
		@(posedge clk) disable iff (!arst_n)
			(out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.perturbation));
	endproperty
	a_out_hold: assert property (p_out_hold) else $error("result dropped");

	property p_win_bound;
		@(posedge clk) disable iff (!arst_n)
			(state_q != ST_IDLE && state_q != ST_CENTER) |-> n_q <= NW'(WD);
	endproperty
	a_win_bound: assert property (p_win_bound) else $error("window count overflow");
endmodule

[sim/tb_windowed_median_detrend.sv]
// Testbench: windowed median detrend, directed and random words checked against a local predictor.
module tb_windowed_median_detrend;
	import wmd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic signed [17:0] pert;
		logic ok;
	} pert_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [IdxW-1:0] cfg_index;
	logic [CfgW-1:0] cfg_data;

	wmd_in_if in_ch ();
	wmd_out_if out_ch ();

	windowed_median_detrend DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	logic [16:0] grid_mem [0:262143];
	bit written [0:262143];
	int rows_raw;
	int cols_raw;
	int hrows_raw;
	int hcols_raw;
	pert_t pert_queue[$];
	int errors;
	bit hold_req;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#60ms;
		$display("status: fail");
		$finish;
	end

	function automatic int clampi(int v, int lo, int hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// clipped window bounds for the current setting
	function automatic void window_of(input int r, input int c,
			output int r0, output int r1, output int c0, output int c1);
		int nr;
		int nc;
		int hr;
		int hc;
		nr = clampi(rows_raw, 1, 512);
		nc = clampi(cols_raw, 1, 512);
		hr = clampi(hrows_raw, 0, 15);
		hc = clampi(hcols_raw, 0, 15);
		r0 = (r > hr) ? r - hr : 0;
		r1 = (r + hr < nr) ? r + hr : nr - 1;
		c0 = (c > hc) ? c - hc : 0;
		c1 = (c + hc < nc) ? c + hc : nc - 1;
	endfunction

	function automatic pert_t detrend_cell(int r, int c);
		pert_t p;
		int r0;
		int r1;
		int c0;
		int c1;
		int vals[$];
		int n;
		int tm;
		logic [16:0] ctr;
		p.pert = '0;
		p.ok = 1'b0;
		if (r >= clampi(rows_raw, 1, 512) || c >= clampi(cols_raw, 1, 512)) return p;
		ctr = grid_mem[r*512+c];
		if (!ctr[16]) return p;
		window_of(r, c, r0, r1, c0, c1);
		for (int i = r0; i <= r1; i++)
			for (int j = c0; j <= c1; j++)
				if (grid_mem[i*512+j][16]) vals.push_back(int'(grid_mem[i*512+j][15:0]));
		n = vals.size();
		if (n == 0) return p;
		vals.sort();
		if (n % 2) tm = 2 * vals[n/2];
		else tm = vals[n/2-1] + vals[n/2];
		p.pert = 18'(2 * int'(ctr[15:0]) - tm);
		p.ok = 1'b1;
		return p;
	endfunction

	task automatic report(string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	task automatic send_word(op_t op, int r, int c, int v, bit ok);
		@(negedge clk);
		in_ch.valid = 1'b1;
		in_ch.op = op;
		in_ch.row = 9'(r);
		in_ch.col = 9'(c);
		in_ch.sample_value = 16'(v);
		in_ch.sample_ok = ok;
		do @(posedge clk); while (!in_ch.ready);
		if (op == OP_WRITE) begin
			grid_mem[r*512+c] = {ok, 16'(v)};
			written[r*512+c] = 1'b1;
		end else begin
			pert_queue.push_back(detrend_cell(r, c));
		end
	endtask

	task automatic idle_gap();
		int n;
		int p;
		p = $urandom_range(0, 99);
		n = (p < 55) ? 0 : (p < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			@(negedge clk);
			in_ch.valid = 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(reg_idx_t idx, int v);
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pert_queue.size() == 0);
		repeat (20) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = CfgW'(v);
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_ROWS: rows_raw = v & 10'h3ff;
			REG_COLS: cols_raw = v & 10'h3ff;
			REG_HROWS: hrows_raw = v & 4'hf;
			REG_HCOLS: hcols_raw = v & 4'hf;
			default: ;
		endcase
	endtask

	task automatic set_shape(int nr, int nc, int hr, int hc);
		write_reg(REG_ROWS, nr);
		write_reg(REG_COLS, nc);
		write_reg(REG_HROWS, hr);
		write_reg(REG_HCOLS, hc);
	endtask

	// writes every unwritten cell the query could touch, then queries
	task automatic query_cell(int r, int c, bit gaps);
		int r0;
		int r1;
		int c0;
		int c1;
		if (r < clampi(rows_raw, 1, 512) && c < clampi(cols_raw, 1, 512)) begin
			window_of(r, c, r0, r1, c0, c1);
			for (int i = r0; i <= r1; i++)
				for (int j = c0; j <= c1; j++)
					if (!written[i*512+j]) begin
						send_word(OP_WRITE, i, j, $urandom, $urandom_range(0, 4) != 0);
						if (gaps) idle_gap();
					end
		end
		send_word(OP_QUERY, r, c, $urandom, $urandom_range(0, 1));
	endtask

	task automatic test_defaults();
		send_word(OP_WRITE, 511, 511, $urandom, 1'b0);
		send_word(OP_QUERY, 511, 511, 0, 1'b0);
		write_reg(REG_ROWS, 3);
		write_reg(REG_COLS, 3);
		query_cell(1, 1, 1'b0);
	endtask

	task automatic test_directed();
		set_shape(0, 1, 0, 0);
		send_word(OP_WRITE, 0, 0, 16'h1234, 1'b0);
		send_word(OP_QUERY, 0, 0, 0, 1'b0);
		send_word(OP_QUERY, 1, 0, 0, 1'b0);
		send_word(OP_QUERY, 0, 1, 0, 1'b0);
		send_word(OP_WRITE, 0, 0, 16'h1234, 1'b1);
		send_word(OP_QUERY, 0, 0, 0, 1'b0);
		set_shape(1, 3, 0, 1);
		send_word(OP_WRITE, 0, 0, 0, 1'b1);
		send_word(OP_WRITE, 0, 1, 16'hffff, 1'b1);
		send_word(OP_WRITE, 0, 2, 0, 1'b1);
		send_word(OP_QUERY, 0, 1, 0, 1'b0);
		send_word(OP_QUERY, 0, 0, 0, 1'b0);
		send_word(OP_WRITE, 0, 0, 16'hffff, 1'b1);
		send_word(OP_WRITE, 0, 1, 0, 1'b1);
		send_word(OP_WRITE, 0, 2, 16'hffff, 1'b1);
		send_word(OP_QUERY, 0, 1, 0, 1'b0);
		send_word(OP_WRITE, 0, 2, 16'h8000, 1'b0);
		send_word(OP_QUERY, 0, 1, 0, 1'b0);
		send_word(OP_WRITE, 511, 511, 16'h5a5a, 1'b1);
		set_shape(1023, 600, 0, 0);
		send_word(OP_QUERY, 511, 511, 0, 1'b0);
		set_shape(2, 2, 15, 15);
		query_cell(1, 1, 1'b0);
	endtask

	task automatic test_random_phase(int items);
		int nr;
		int nc;
		int p;
		nr = clampi(rows_raw, 1, 512);
		nc = clampi(cols_raw, 1, 512);
		for (int k = 0; k < items; k++) begin
			p = $urandom_range(0, 99);
			if (p < 35)
				send_word(OP_WRITE, $urandom_range(0, nr - 1), $urandom_range(0, nc - 1),
					$urandom, $urandom_range(0, 4) != 0);
			else if (p < 40)
				send_word(OP_WRITE, $urandom_range(0, 511), $urandom_range(0, 511),
					$urandom, $urandom_range(0, 1));
			else if (p < 45 && nr < 512)
				send_word(OP_QUERY, $urandom_range(nr, 511), $urandom_range(0, 511), 0, 1'b0);
			else
				query_cell($urandom_range(0, nr - 1), $urandom_range(0, nc - 1), 1'b1);
			idle_gap();
		end
	endtask

	task automatic test_random();
		set_shape($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 3),
			$urandom_range(0, 3));
		test_random_phase(12);
		set_shape($urandom_range(1, 6), $urandom_range(1, 6), 15, 15);
		test_random_phase(10);
		set_shape(512, 512, $urandom_range(0, 1), $urandom_range(0, 1));
		test_random_phase(6);
		set_shape($urandom_range(3, 8), $urandom_range(3, 8), $urandom_range(0, 15),
			$urandom_range(0, 15));
		test_random_phase(12);
	endtask

	task automatic test_backpressure();
		set_shape(3, 3, 1, 1);
		for (int i = 0; i < 3; i++)
			for (int j = 0; j < 3; j++)
				send_word(OP_WRITE, i, j, $urandom, 1'b1);
		hold_req = 1'b1;
		for (int k = 0; k < 6; k++) begin
			send_word(OP_WRITE, $urandom_range(0, 2), $urandom_range(0, 2), $urandom, 1'b1);
			send_word(OP_QUERY, $urandom_range(0, 2), $urandom_range(0, 2), 0, 1'b0);
		end
	endtask

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		int p;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ch.ready = 1'b0;
				repeat (3000) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				p = $urandom_range(0, 99);
				if (p < 60) out_ch.ready = 1'b1;
				else if (p < 92) out_ch.ready = 1'b0;
				else begin
					out_ch.ready = 1'b0;
					repeat ($urandom_range(10, 60)) @(negedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		pert_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pert_queue.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				e = pert_queue.pop_front();
				if (out_ch.result_ok !== e.ok)
					report($sformatf("result_ok %b expected %b", out_ch.result_ok, e.ok));
				if (out_ch.perturbation !== e.pert)
					report($sformatf("perturbation %0d expected %0d",
						out_ch.perturbation, e.pert));
			end
		end
	end

	initial begin
		errors = 0;
		hold_req = 1'b0;
		rows_raw = 512;
		cols_raw = 512;
		hrows_raw = 10;
		hcols_raw = 10;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_ROWS;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.op = OP_WRITE;
		in_ch.row = '0;
		in_ch.col = '0;
		in_ch.sample_value = '0;
		in_ch.sample_ok = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		test_defaults();
		test_directed();
		test_random();
		test_backpressure();
		@(negedge clk);
		in_ch.valid = 1'b0;
		wait (pert_queue.size() == 0);
		repeat (100) @(negedge clk);
		if (errors == 0) $display("status: pass");
		else $display("status: fail");
		$finish;
	end
endmodule

[filelist.f]
src/wmd_pkg.sv
src/wmd_if.sv
src/windowed_median_detrend.sv
sim/tb_windowed_median_detrend.sv
